/* rtl/core/s2c_pkg.sv */
// Shared constants, widths and arctangent table for the spherical to Cartesian unit.
`default_nettype none
package s2c_pkg;
    localparam int MAG_WIDTH     = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int OUT_WIDTH     = MAG_WIDTH + 1;
    localparam int CW            = 34;
    localparam int ZW            = 33;
    localparam int TRIG_W        = 17;
    localparam int SC_LAT        = CORDIC_STAGES + 3;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            default: v = 32'd81;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/s2c_sincos.sv */
// Pipelined CORDIC sine and cosine with quadrant folding, Q1.15 results.
`default_nettype none
module s2c_sincos
    import s2c_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic [ANGLE_WIDTH-1:0]   i_angle,
    output logic signed [TRIG_W-1:0]      o_sin,
    output logic signed [TRIG_W-1:0]      o_cos
);
    logic signed [CW-1:0] r_x [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_y [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z [0:CORDIC_STAGES];
    logic [1:0]           r_q [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_c, r_s;
    logic signed [TRIG_W-1:0] r_sin, r_cos;

    logic [31:0] a32, a_off, resid;
    logic [1:0]  q0;
    logic signed [CW-1:0] n_c, n_s;

    assign a32   = {i_angle, {(32-ANGLE_WIDTH){1'b0}}};
    assign a_off = a32 + 32'h2000_0000;
    assign q0    = a_off[31:30];
    assign resid = a32 - {q0, 30'b0};

    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= ZW'(signed'(resid));
        r_q[0] <= q0;
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] at;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        assign at = signed'({1'b0, atan_turn(k)});
        always_ff @(posedge i_clk) begin
            r_q[k+1] <= r_q[k];
            if (!r_z[k][ZW-1]) begin
                r_x[k+1] <= r_x[k] - dx;
                r_y[k+1] <= r_y[k] + dy;
                r_z[k+1] <= r_z[k] - at;
            end else begin
                r_x[k+1] <= r_x[k] + dx;
                r_y[k+1] <= r_y[k] - dy;
                r_z[k+1] <= r_z[k] + at;
            end
        end
    end

    always_comb begin
        case (r_q[CORDIC_STAGES])
            2'd0: begin
                n_c = r_x[CORDIC_STAGES];
                n_s = r_y[CORDIC_STAGES];
            end
            2'd1: begin
                n_c = -r_y[CORDIC_STAGES];
                n_s = r_x[CORDIC_STAGES];
            end
            2'd2: begin
                n_c = -r_x[CORDIC_STAGES];
                n_s = -r_y[CORDIC_STAGES];
            end
            default: begin
                n_c = r_y[CORDIC_STAGES];
                n_s = -r_x[CORDIC_STAGES];
            end
        endcase
    end

    function automatic logic signed [TRIG_W-1:0] round_q15(input logic signed [CW-1:0] v);
        logic [CW-1:0]    mag;
        logic [CW-1:0]    sum;
        logic [CW-16:0]   m;
        logic [TRIG_W-1:0] mc;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        sum = mag + CW'(1 << 14);
        m   = sum[CW-1:15];
        mc  = (m > (CW-15)'(32768)) ? TRIG_W'(32768) : m[TRIG_W-1:0];
        return v[CW-1] ? signed'(-mc) : signed'(mc);
    endfunction

    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_s   <= n_s;
        r_cos <= round_q15(r_c);
        r_sin <= round_q15(r_s);
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule
`default_nettype wire

/* rtl/core/spherical_to_cartesian_unit.sv */
// Top level: spherical to Cartesian conversion pipeline.
// start is carried to o_valid through the r_vld shift register, alongside the data path.
// Throughput: one transaction per cycle; busy is never raised.
// Depth is set by the CORDIC stage chain plus rounding and two multiply stages.
// Synchronous active-low reset clears the valid pipeline; data needs no reset.
`default_nettype none
module spherical_to_cartesian_unit
    import s2c_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [MAG_WIDTH-1:0]        i_magnitude,
    input  wire logic [ANGLE_WIDTH-1:0]      i_polar_angle,
    input  wire logic [ANGLE_WIDTH-1:0]      i_azimuth_angle,
    output logic                             o_valid,
    output logic signed [OUT_WIDTH-1:0]      o_x_component,
    output logic signed [OUT_WIDTH-1:0]      o_y_component,
    output logic signed [OUT_WIDTH-1:0]      o_z_component
);
    localparam int PW = 2 * TRIG_W;
    localparam int FW = 31;
    localparam int XPW = MAG_WIDTH + FW;
    localparam int ZPW = MAG_WIDTH + 16;

    logic signed [TRIG_W-1:0] st, ct, sp, cp;
    logic                 r_vld [0:SC_LAT+2];
    logic [MAG_WIDTH-1:0] r_mag [0:SC_LAT-1];

    logic signed [PW-1:0]     r_fx, r_fy;
    logic signed [TRIG_W-1:0] r_ct;
    logic [MAG_WIDTH-1:0]     r_mag1;
    logic [XPW-1:0] r_px, r_py;
    logic [ZPW-1:0] r_pz;
    logic r_nx, r_ny, r_nz;
    logic signed [OUT_WIDTH-1:0] r_xo, r_yo, r_zo;

    logic [PW-1:0] fx_abs, fy_abs;
    logic [TRIG_W-1:0] ct_abs;
    logic [XPW-1:0] sx, sy;
    logic [ZPW-1:0] sz;

    assign busy = 1'b0;

    s2c_sincos u_polar (
        .i_clk   (i_clk),
        .i_angle (i_polar_angle),
        .o_sin   (st),
        .o_cos   (ct)
    );

    s2c_sincos u_azim (
        .i_clk   (i_clk),
        .i_angle (i_azimuth_angle),
        .o_sin   (sp),
        .o_cos   (cp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SC_LAT + 2; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= start;
            for (int k = 1; k <= SC_LAT + 2; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag[0] <= i_magnitude;
        for (int k = 1; k < SC_LAT; k++) r_mag[k] <= r_mag[k-1];
    end

    assign fx_abs = r_fx[PW-1] ? PW'(-r_fx) : PW'(r_fx);
    assign fy_abs = r_fy[PW-1] ? PW'(-r_fy) : PW'(r_fy);
    assign ct_abs = r_ct[TRIG_W-1] ? TRIG_W'(-r_ct) : TRIG_W'(r_ct);

    assign sx = r_px + XPW'(1 << 29);
    assign sy = r_py + XPW'(1 << 29);
    assign sz = r_pz + ZPW'(1 << 14);

    always_ff @(posedge i_clk) begin
        r_fx   <= st * cp;
        r_fy   <= st * sp;
        r_ct   <= ct;
        r_mag1 <= r_mag[SC_LAT-1];

        r_px <= XPW'(r_mag1) * XPW'(fx_abs[FW-1:0]);
        r_py <= XPW'(r_mag1) * XPW'(fy_abs[FW-1:0]);
        r_pz <= ZPW'(r_mag1) * ZPW'(ct_abs[15:0]);
        r_nx <= r_fx[PW-1];
        r_ny <= r_fy[PW-1];
        r_nz <= r_ct[TRIG_W-1];

        r_xo <= r_nx ? signed'(-sx[30+OUT_WIDTH-1:30]) : signed'(sx[30+OUT_WIDTH-1:30]);
        r_yo <= r_ny ? signed'(-sy[30+OUT_WIDTH-1:30]) : signed'(sy[30+OUT_WIDTH-1:30]);
        r_zo <= r_nz ? signed'(-sz[15+OUT_WIDTH-1:15]) : signed'(sz[15+OUT_WIDTH-1:15]);
    end

    assign o_valid       = r_vld[SC_LAT+2];
    assign o_x_component = r_xo;
    assign o_y_component = r_yo;
    assign o_z_component = r_zo;

    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_z_component <= 25'sd16777215 && o_z_component >= -25'sd16777215))
        else $error("z out of range");
endmodule
`default_nettype wire

/* tb/s2c_checker.sv */
// Checker for the spherical to Cartesian unit: predicts each transaction and compares results.
`timescale 1ns / 1ps
module s2c_checker
    import s2c_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire logic                   busy,
    input  wire logic [MAG_WIDTH-1:0]   i_magnitude,
    input  wire logic [ANGLE_WIDTH-1:0] i_polar_angle,
    input  wire logic [ANGLE_WIDTH-1:0] i_azimuth_angle,
    input  wire logic                   o_valid,
    input  wire logic [OUT_WIDTH-1:0]   o_x_component,
    input  wire logic [OUT_WIDTH-1:0]   o_y_component,
    input  wire logic [OUT_WIDTH-1:0]   o_z_component,
    output int                          fail_count,
    output int                          pending_count
);
    typedef struct packed {
        logic [OUT_WIDTH-1:0] x;
        logic [OUT_WIDTH-1:0] y;
        logic [OUT_WIDTH-1:0] z;
    } t_coord;

    t_coord cart_q[$];

    function automatic longint unsigned atan_entry(input int idx);
        case (idx)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            default: return 81;
        endcase
    endfunction

    function automatic longint round_away(input longint v, input int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 32768) return 32768;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void turn_trig(input logic [ANGLE_WIDTH-1:0] ang,
                                      output longint sn, output longint cs);
        logic [31:0] a32, resid;
        logic [1:0] quad;
        longint xr, yr, zr, dx, dy, c, s;
        int n;
        a32 = 32'(ang) << (32 - ANGLE_WIDTH);
        quad = 2'((a32 + 32'h2000_0000) >> 30);
        resid = a32 - (32'(quad) << 30);
        zr = longint'($signed(resid));
        xr = 652032874;
        yr = 0;
        n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
        for (int i = 0; i < n; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0) begin
                xr -= dx; yr += dy; zr -= longint'(atan_entry(i));
            end else begin
                xr += dx; yr -= dy; zr += longint'(atan_entry(i));
            end
        end
        case (quad)
            2'd0: begin c = xr;  s = yr;  end
            2'd1: begin c = -yr; s = xr;  end
            2'd2: begin c = -xr; s = -yr; end
            default: begin c = yr; s = -xr; end
        endcase
        cs = clamp_unit(round_away(c, 15));
        sn = clamp_unit(round_away(s, 15));
    endfunction

    function automatic t_coord to_cartesian(input logic [MAG_WIDTH-1:0] mag,
                                            input logic [ANGLE_WIDTH-1:0] pol,
                                            input logic [ANGLE_WIDTH-1:0] azi);
        longint st, ct, sp, cp, r;
        t_coord res;
        turn_trig(pol, st, ct);
        turn_trig(azi, sp, cp);
        r = longint'(mag);
        res.x = OUT_WIDTH'(round_away(r * st * cp, 30));
        res.y = OUT_WIDTH'(round_away(r * st * sp, 30));
        res.z = OUT_WIDTH'(round_away(r * ct, 15));
        return res;
    endfunction

    initial pending_count = 0;

    always @(posedge i_clk) begin
        t_coord exp_c;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (start && !busy)
                cart_q.push_back(to_cartesian(i_magnitude, i_polar_angle, i_azimuth_angle));
            if (o_valid) begin
                if (cart_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result x=%0d y=%0d z=%0d",
                                 $signed(o_x_component), $signed(o_y_component),
                                 $signed(o_z_component));
                    fail_count <= fail_count + 1;
                end else begin
                    exp_c = cart_q.pop_front();
                    if (exp_c.x !== o_x_component || exp_c.y !== o_y_component ||
                        exp_c.z !== o_z_component) begin
                        if (fail_count < 10)
                            $display("mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     $signed(exp_c.x), $signed(exp_c.y), $signed(exp_c.z),
                                     $signed(o_x_component), $signed(o_y_component),
                                     $signed(o_z_component));
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count = cart_q.size();
    end
endmodule

/* tb/testbench.sv */
// Testbench top: stimulus for the spherical to Cartesian unit and the final verdict.
`timescale 1ns / 1ps
module testbench;
    import s2c_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [MAG_WIDTH-1:0]   i_magnitude;
    logic [ANGLE_WIDTH-1:0] i_polar_angle;
    logic [ANGLE_WIDTH-1:0] i_azimuth_angle;
    logic                   o_valid;
    logic [OUT_WIDTH-1:0]   o_x_component;
    logic [OUT_WIDTH-1:0]   o_y_component;
    logic [OUT_WIDTH-1:0]   o_z_component;
    int                     fail_count;
    int                     pending_count;
    int                     idle_cycles;

    spherical_to_cartesian_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_magnitude(i_magnitude), .i_polar_angle(i_polar_angle),
        .i_azimuth_angle(i_azimuth_angle), .o_valid(o_valid),
        .o_x_component(o_x_component), .o_y_component(o_y_component),
        .o_z_component(o_z_component)
    );

    s2c_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_magnitude(i_magnitude), .i_polar_angle(i_polar_angle),
        .i_azimuth_angle(i_azimuth_angle), .o_valid(o_valid),
        .o_x_component(o_x_component), .o_y_component(o_y_component),
        .o_z_component(o_z_component), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_vector(input logic [MAG_WIDTH-1:0] mag,
                               input logic [ANGLE_WIDTH-1:0] pol,
                               input logic [ANGLE_WIDTH-1:0] azi,
                               input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_magnitude     <= mag;
        i_polar_angle   <= pol;
        i_azimuth_angle <= azi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    function automatic logic [ANGLE_WIDTH-1:0] random_angle();
        case ($urandom_range(0, 3))
            0: return ANGLE_WIDTH'($urandom_range(0, 7) << (ANGLE_WIDTH - 3));
            1: return ANGLE_WIDTH'((($urandom_range(0, 7) << (ANGLE_WIDTH - 3))
                                   + $urandom_range(0, 6)) - 3);
            default: return ANGLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [MAG_WIDTH-1:0] random_magnitude();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return MAG_WIDTH'($urandom_range(0, 3));
            2: return MAG_WIDTH'(1) << $urandom_range(0, MAG_WIDTH - 1);
            default: return MAG_WIDTH'($urandom);
        endcase
    endfunction

    initial begin
        logic [ANGLE_WIDTH-1:0] quarter;
        int gap;
        quarter         = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_magnitude     = '0;
        i_polar_angle   = '0;
        i_azimuth_angle = '0;
        idle_cycles     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_vector('0, '0, '0, 0);
        send_vector('0, 16'h1234, 16'h5678, 0);
        send_vector('1, '0, '0, 0);
        send_vector('1, quarter, '0, 0);
        send_vector('1, quarter, quarter, 1);
        send_vector('1, ANGLE_WIDTH'(2 * quarter), quarter, 0);
        send_vector('1, ANGLE_WIDTH'(3 * quarter), ANGLE_WIDTH'(3 * quarter), 0);
        send_vector('1, '1, '1, 2);
        send_vector('1, quarter >> 1, quarter >> 1, 0);
        send_vector('1, ANGLE_WIDTH'((quarter >> 1) - 1), ANGLE_WIDTH'((quarter >> 1) + 1), 0);
        send_vector(24'h00_0001, quarter, quarter >> 1, 0);
        send_vector(24'h01_0000, quarter >> 1, ANGLE_WIDTH'(3 * quarter + 7), 0);
        send_vector(24'h80_0000, 16'h8000, 16'h7FFF, 0);
        send_vector(24'h7F_FFFF, 16'h5555, 16'hAAAA, 0);
        send_vector(24'hAA_AAAA, 16'hAAAA, 16'h5555, 3);

        for (int n = 0; n < 700; n++) begin
            if (n == 350) begin
                drain();
            end
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            if (n >= 500 && n < 600) gap = 0;
            send_vector(random_magnitude(), random_angle(), random_angle(), gap);
        end

        drain();
        repeat (SC_LAT + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/core/s2c_pkg.sv
rtl/core/s2c_sincos.sv
rtl/core/spherical_to_cartesian_unit.sv
tb/s2c_checker.sv
tb/testbench.sv
